// ===== src/pdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdpc_pkg
// Shared types and constants for the periodic disk placement check: request
// and result payloads, status and register codes, sequencer states.
// ----------------------------------------------------------------------------
package pdpc_pkg;

  // Default depth of the centre store
  localparam int unsigned PDPC_MAX_DISKS = 1024;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int LEN_W     = 16;
  localparam int RADIUS_W  = 15;
  localparam int COUNT_W   = 11;
  localparam int ATT_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 3;

  // Datapath widths: per-axis distance, its square, 4R^2
  localparam int DIST_W = COORD_W + 1;
  localparam int SQ_W   = 2 * DIST_W;
  localparam int LIM_W  = 2 * (RADIUS_W + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_WIDTH    = 3'd0,
    CFG_BOX_HEIGHT   = 3'd1,
    CFG_DISK_RADIUS  = 3'd2,
    CFG_TARGET_COUNT = 3'd3,
    CFG_MAX_ATTEMPTS = 3'd4
  } cfg_index_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_GAVE_UP   = 3'd2,
    ST_RUN_OVER  = 3'd3,
    ST_RESTARTED = 3'd4
  } status_t;

  // Incoming request: one candidate centre
  typedef struct packed {
    logic                      restart;
    logic signed [COORD_W-1:0] cand_x;
    logic signed [COORD_W-1:0] cand_y;
  } in_req_t;

  // Outgoing request: result of one candidate
  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] placed_count;
    logic [ATT_W-1:0]   attempts_used;
  } out_req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_DIST,
    S_SQX,
    S_SQY,
    S_CMP,
    S_POST
  } state_t;

  // What the current candidate turned out to be
  typedef enum logic [1:0] {
    OC_RESTART,
    OC_RUN_OVER,
    OC_PLACE,
    OC_HIT
  } outcome_t;

endpackage

// ===== src/periodic_disk_placement_check_top.sv =====
// ----------------------------------------------------------------------------
// periodic_disk_placement_check_top
// Checks one candidate disk centre against all centres placed so far in a
// periodic box (minimum image per axis), stores it if clear, and keeps the
// placed and attempt counts of the run.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------
//  in      | in  | in_valid / in_stall  | in_req  (restart, cand_x/y)
//  out     | out | out_valid / out_stall| out_req (status, counts)
//  cfg     | in  | cfg_we               | cfg_index, cfg_data
//
//  A restart, a run-over candidate or the first disk of a run goes straight
//  to the write-back; otherwise the stored centres are compared in turn (at
//  most the placed count), each through DIST, SQX, SQY and CMP on the single
//  shared squarer (dx^2 then dy^2) fed from the one read port of the store.
//  Reset clears state, counters and flags and loads the default settings; the
//  store is not cleared, only entries written in the current run are read.
//  A result waits in an output register; the next request is taken meanwhile,
//  and only the final write-back waits while out_stall holds the register.
//
module periodic_disk_placement_check_top #(
  parameter int unsigned MAX_DISKS = pdpc_pkg::PDPC_MAX_DISKS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pdpc_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pdpc_pkg::out_req_t                  out_req,
  input  logic                                cfg_we,
  input  logic [pdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdpc_pkg::CFG_W-1:0]          cfg_data
);
  import pdpc_pkg::*;

  localparam int unsigned AW          = $clog2(MAX_DISKS);
  localparam logic [31:0] MAX_DISKS_W = 32'(MAX_DISKS);

  // Minimum-image distance on one axis: min(|d|, ||L| - |d||)
  function automatic logic [DIST_W-1:0] axis_dist(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b,
    input logic [LEN_W-1:0]          len
  );
    logic signed [DIST_W-1:0] d;
    logic [DIST_W-1:0]        ad;
    logic signed [DIST_W:0]   w;
    logic [DIST_W-1:0]        aw;
    d  = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    ad = d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
    w  = {2'b00, len} - {1'b0, ad};
    aw = w[DIST_W] ? DIST_W'(-w) : w[DIST_W-1:0];
    return (ad < aw) ? ad : aw;
  endfunction

  // Configuration registers
  logic [LEN_W-1:0]    box_width;
  logic [LEN_W-1:0]    box_height;
  logic [RADIUS_W-1:0] disk_radius;
  logic [COUNT_W-1:0]  target_count;
  logic [ATT_W-1:0]    max_attempts;

  // Run state
  logic [COUNT_W-1:0] accepted_count;
  logic [ATT_W-1:0]   attempt_counter;
  logic               run_stopped;

  // Sequencer and datapath registers
  state_t             state;
  state_t             state_next;
  in_req_t            req;
  outcome_t           outcome;
  outcome_t           outcome_lim;
  logic [COUNT_W-1:0] j;
  logic [COUNT_W-1:0] j_inc;
  logic [LIM_W-1:0]   lim;
  logic [DIST_W-1:0]  dx;
  logic [DIST_W-1:0]  dy;
  logic [SQ_W-1:0]    prod;
  logic [SQ_W-1:0]    sqx;
  logic [SQ_W:0]      dist_sq;
  logic               hit;
  logic               run_over;
  logic               short_path;

  // Centre store
  logic signed [COORD_W-1:0] centre_x_store [MAX_DISKS];
  logic signed [COORD_W-1:0] centre_y_store [MAX_DISKS];
  logic signed [COORD_W-1:0] rd_x;
  logic signed [COORD_W-1:0] rd_y;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;

  // Shared squarer
  logic [DIST_W-1:0] mul_a;
  logic [SQ_W-1:0]   mul_out;

  // Handshake and write-back
  logic               in_fire;
  logic               out_free;
  logic               post_fire;
  logic [COUNT_W-1:0] cnt_inc;
  logic [ATT_W-1:0]   att_inc;
  logic [COUNT_W-1:0] count_next;
  logic [ATT_W-1:0]   attempt_next;
  logic               stopped_next;
  status_t            status_next;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign j_inc    = j + 1'b1;

  // Run-over check and first classification of the candidate
  assign run_over = run_stopped || (accepted_count >= target_count) ||
                    (32'(accepted_count) >= MAX_DISKS_W);

  always_comb begin
    priority if (req.restart) begin
      outcome_lim = OC_RESTART;
    end else if (run_over) begin
      outcome_lim = OC_RUN_OVER;
    end else begin
      outcome_lim = OC_PLACE;
    end
  end

  assign short_path = req.restart || run_over || (accepted_count == '0);

  // Squared distance against 4R^2
  assign dist_sq = {1'b0, sqx} + {1'b0, prod};
  assign hit     = dist_sq < (SQ_W + 1)'(lim);
  assign mul_out = SQ_W'(mul_a) * SQ_W'(mul_a);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_LIMIT;
      S_LIMIT: state_next = short_path ? S_POST : S_DIST;
      S_DIST:  state_next = S_SQX;
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_CMP;
      S_CMP: begin
        if (hit || (j_inc == accepted_count)) state_next = S_POST;
        else state_next = S_DIST;
      end
      S_POST:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    rd_en     = 1'b0;
    rd_addr   = '0;
    mul_a     = '0;
    post_fire = 1'b0;
    unique case (state)
      S_LIMIT: begin
        rd_en = 1'b1;
        mul_a = {1'b0, disk_radius, 1'b0};
      end
      S_SQX:   mul_a = dx;
      S_SQY: begin
        mul_a   = dy;
        rd_en   = 1'b1;
        rd_addr = AW'(j_inc);
      end
      S_POST:  post_fire = out_free;
      default: ;
    endcase
  end

  assign wr_en = post_fire && (outcome == OC_PLACE);

  // Counter updates and result of the finished candidate
  always_comb begin
    cnt_inc      = accepted_count + 1'b1;
    att_inc      = attempt_counter + 1'b1;
    count_next   = accepted_count;
    attempt_next = attempt_counter;
    stopped_next = run_stopped;
    status_next  = ST_RUN_OVER;
    unique case (outcome)
      OC_RESTART: begin
        count_next   = '0;
        attempt_next = '0;
        stopped_next = 1'b0;
        status_next  = ST_RESTARTED;
      end
      OC_RUN_OVER: status_next = ST_RUN_OVER;
      OC_PLACE: begin
        count_next   = cnt_inc;
        attempt_next = '0;
        stopped_next = run_stopped || (cnt_inc >= target_count) ||
                       (32'(cnt_inc) >= MAX_DISKS_W);
        status_next  = ST_ACCEPTED;
      end
      OC_HIT: begin
        attempt_next = att_inc;
        if (att_inc >= max_attempts) begin
          stopped_next = 1'b1;
          status_next  = ST_GAVE_UP;
        end else begin
          status_next  = ST_REJECTED;
        end
      end
      default: ;
    endcase
  end

  // Centre store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      centre_x_store[AW'(accepted_count)] <= req.cand_x;
      centre_y_store[AW'(accepted_count)] <= req.cand_y;
    end
    if (rd_en) begin
      rd_x <= centre_x_store[rd_addr];
      rd_y <= centre_y_store[rd_addr];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) req <= in_req;
    unique case (state)
      S_LIMIT: begin
        lim     <= mul_out[LIM_W-1:0];
        outcome <= outcome_lim;
        j       <= '0;
      end
      S_DIST: begin
        dx <= axis_dist(rd_x, req.cand_x, box_width);
        dy <= axis_dist(rd_y, req.cand_y, box_height);
      end
      S_SQX:   prod <= mul_out;
      S_SQY: begin
        prod <= mul_out;
        sqx  <= prod;
      end
      S_CMP: begin
        if (hit) outcome <= OC_HIT;
        j <= j_inc;
      end
      default: ;
    endcase
    if (post_fire) out_req <= '{status: status_next, placed_count: count_next,
                                attempts_used: attempt_next};
  end

  // Control state, run counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      accepted_count  <= '0;
      attempt_counter <= '0;
      run_stopped     <= 1'b0;
      box_width       <= LEN_W'(256);
      box_height      <= LEN_W'(256);
      disk_radius     <= RADIUS_W'(16);
      target_count    <= COUNT_W'(1024);
      max_attempts    <= '1;
    end else begin
      state <= state_next;
      if (post_fire) begin
        out_valid       <= 1'b1;
        accepted_count  <= count_next;
        attempt_counter <= attempt_next;
        run_stopped     <= stopped_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_BOX_WIDTH:    box_width    <= cfg_data[LEN_W-1:0];
          CFG_BOX_HEIGHT:   box_height   <= cfg_data[LEN_W-1:0];
          CFG_DISK_RADIUS:  disk_radius  <= cfg_data[RADIUS_W-1:0];
          CFG_TARGET_COUNT: target_count <= cfg_data[COUNT_W-1:0];
          CFG_MAX_ATTEMPTS: max_attempts <= cfg_data[ATT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/pdpc_checker.sv =====
// ----------------------------------------------------------------------------
// pdpc_checker
// Port-level checks on the periodic disk placement check, bound to the top.
// ----------------------------------------------------------------------------
module pdpc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input pdpc_pkg::in_req_t              in_req,
  input logic                           out_valid,
  input logic                           out_stall,
  input pdpc_pkg::out_req_t             out_req,
  input logic                           cfg_we,
  input logic [pdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [pdpc_pkg::CFG_W-1:0]     cfg_data
);
  import pdpc_pkg::*;

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("stalled result changed");

  // A restart clears both counts
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_req.status == ST_RESTARTED) |->
      (out_req.placed_count == '0) && (out_req.attempts_used == '0))
    else $error("restart result with non-zero counts");

  // An accepted disk resets the attempts and counts at least one disk
  a_accept_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_req.status == ST_ACCEPTED) |->
      (out_req.attempts_used == '0) && (out_req.placed_count != '0))
    else $error("accepted result with inconsistent counts");

  // An overlap rejection always has a counted attempt
  a_reject_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_req.status == ST_REJECTED) |-> (out_req.attempts_used != '0))
    else $error("rejection without a counted attempt");

endmodule

bind periodic_disk_placement_check_top pdpc_checker u_pdpc_checker (.*);

// ===== bench/tb_periodic_disk_placement_check_top.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_disk_placement_check_top
// Self-checking bench for the periodic disk placement check. Candidate centres
// are fed from a queue by a clocked driver and each accepted request is run
// through a local model of the placement rules (minimum-image spacing, placed
// and attempt counts, stop conditions). Results are checked in order against
// the model. A directed opening covers the field extremes and special cases,
// then random runs with random geometry follow, under varying backpressure.
// ----------------------------------------------------------------------------
module tb_periodic_disk_placement_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pdpc_pkg::*;

  localparam int MODEL_DEPTH    = PDPC_MAX_DISKS;
  localparam int ITEM_TARGET    = 580;
  localparam int HOLD_AT_REQ    = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_CAP     = 50;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_req_t              in_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_req_t             out_req;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Requests waiting to be driven, results the model says are due
  in_req_t  pending_cands[$];
  out_req_t predicted_results[$];

  // Local copy of the block's settings and run state
  logic [LEN_W-1:0]           geo_width;
  logic [LEN_W-1:0]           geo_height;
  logic [RADIUS_W-1:0]        geo_radius;
  logic [COUNT_W-1:0]         geo_target;
  logic [ATT_W-1:0]           geo_max_att;
  logic signed [COORD_W-1:0]  placed_x [MODEL_DEPTH];
  logic signed [COORD_W-1:0]  placed_y [MODEL_DEPTH];
  int                         model_placed;
  logic [ATT_W-1:0]           model_attempts;
  bit                         model_stopped;

  int req_count = 0;
  int err_count = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int tx_idle_pct;
  int rx_idle_pct;

  periodic_disk_placement_check_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Backpressure profile: sender light / receiver heavy, then swapped, then none
  assign tx_idle_pct = (req_count < 190) ? 13 : (req_count < 380) ? 54 : 0;
  assign rx_idle_pct = (req_count < 190) ? 54 : (req_count < 380) ? 13 : 0;

  // Minimum-image distance on one axis
  function automatic longint axis_gap(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b,
                                      logic [LEN_W-1:0] len);
    longint d;
    longint w;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    w = longint'({1'b0, len}) - d;
    if (w < 0) w = -w;
    return (d < w) ? d : w;
  endfunction

  // Placement rules: updates the run state and returns the due result
  function automatic out_req_t predict_placement(in_req_t req);
    out_req_t res;
    bit       hit;
    longint   lim;
    longint   dx;
    longint   dy;
    int       j;
    hit = 1'b0;
    lim = 64'd4 * longint'({1'b0, geo_radius}) * longint'({1'b0, geo_radius});
    if (req.restart) begin
      model_placed   = 0;
      model_attempts = '0;
      model_stopped  = 1'b0;
      res.status     = ST_RESTARTED;
    end else if (model_stopped || model_placed >= int'(geo_target) ||
                 model_placed >= MODEL_DEPTH) begin
      res.status = ST_RUN_OVER;
    end else begin
      for (j = 0; j < model_placed && !hit; j++) begin
        dx = axis_gap(placed_x[j], req.cand_x, geo_width);
        dy = axis_gap(placed_y[j], req.cand_y, geo_height);
        if (dx * dx + dy * dy < lim) hit = 1'b1;
      end
      if (!hit) begin
        placed_x[model_placed] = req.cand_x;
        placed_y[model_placed] = req.cand_y;
        model_placed++;
        model_attempts = '0;
        if (model_placed >= int'(geo_target) || model_placed >= MODEL_DEPTH)
          model_stopped = 1'b1;
        res.status = ST_ACCEPTED;
      end else begin
        model_attempts = model_attempts + 1'b1;
        if (model_attempts >= geo_max_att) begin
          model_stopped = 1'b1;
          res.status    = ST_GAVE_UP;
        end else begin
          res.status = ST_REJECTED;
        end
      end
    end
    res.placed_count  = model_placed[COUNT_W-1:0];
    res.attempts_used = model_attempts;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < REPORT_CAP)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  // Driver: next candidate once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_cands.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_req   <= pending_cands.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to fill the block up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && req_count >= HOLD_AT_REQ) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: register writes, accepted requests into the model, result check
  always @(posedge clk) begin
    out_req_t due;
    if (rst) begin
      geo_width      <= 16'd256;
      geo_height     <= 16'd256;
      geo_radius     <= 15'd16;
      geo_target     <= 11'd1024;
      geo_max_att    <= 24'hFFFFFF;
      model_placed   = 0;
      model_attempts = '0;
      model_stopped  = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOX_WIDTH:    geo_width   <= cfg_data[LEN_W-1:0];
          CFG_BOX_HEIGHT:   geo_height  <= cfg_data[LEN_W-1:0];
          CFG_DISK_RADIUS:  geo_radius  <= cfg_data[RADIUS_W-1:0];
          CFG_TARGET_COUNT: geo_target  <= cfg_data[COUNT_W-1:0];
          CFG_MAX_ATTEMPTS: geo_max_att <= cfg_data[ATT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        due = predict_placement(in_req);
        predicted_results.push_back(due);
        req_count <= req_count + 1;
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with none due, status", out_req.status, -1);
        end else begin
          due = predicted_results.pop_front();
          if (out_req.status !== due.status)
            report_mismatch("status", out_req.status, due.status);
          if (out_req.placed_count !== due.placed_count)
            report_mismatch("placed_count", out_req.placed_count, due.placed_count);
          if (out_req.attempts_used !== due.attempts_used)
            report_mismatch("attempts_used", out_req.attempts_used, due.attempts_used);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_periodic_disk_placement_check_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cand(bit restart, int x, int y);
    in_req_t req;
    req.restart = restart;
    req.cand_x  = x[COORD_W-1:0];
    req.cand_y  = y[COORD_W-1:0];
    pending_cands.push_back(req);
  endtask

  // Wait until the block has nothing in flight
  task automatic wait_idle;
    @(negedge clk);
    while (pending_cands.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
  endtask

  task automatic end_writes;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(int unsigned bw, int unsigned bh, int unsigned r,
                                int unsigned tgt, int unsigned max_att);
    write_reg(CFG_BOX_WIDTH, bw);
    write_reg(CFG_BOX_HEIGHT, bh);
    write_reg(CFG_DISK_RADIUS, r);
    write_reg(CFG_TARGET_COUNT, tgt);
    write_reg(CFG_MAX_ATTEMPTS, max_att);
    end_writes();
  endtask

  function automatic int unsigned pick_len();
    case ($urandom_range(19))
      0:       return 0;
      1:       return 1;
      2:       return 16'hFFFF;
      default: return $urandom_range(64, 2048);
    endcase
  endfunction

  // Mostly inside the box, some just outside, some anywhere in range
  function automatic int pick_coord(int unsigned len);
    int span;
    int v;
    span = (len == 0) ? 256 : int'(len);
    case ($urandom_range(19))
      0, 1, 2: v = int'($urandom_range(65535)) - 32768;
      3, 4, 5: begin
        v = int'($urandom_range(3 * span - 1)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      default: v = int'($urandom_range(span - 1));
    endcase
    return v;
  endfunction

  // One phase: fresh geometry, then restart-led runs with some noise
  task automatic random_phase(int budget);
    int unsigned bw;
    int unsigned bh;
    int unsigned r;
    int unsigned tgt;
    int unsigned max_att;
    int unsigned span;
    int n_items;
    int phase_len;
    int run_len;
    int k;
    bw = pick_len();
    bh = pick_len();
    span = (bw == 0 || bh == 0) ? 256 : ((bw < bh) ? bw : bh);
    case ($urandom_range(11))
      0:       r = 0;
      1:       r = 32767;
      default: r = $urandom_range(span / 5);
    endcase
    case ($urandom_range(19))
      0:       tgt = 0;
      1, 2:    tgt = 1024;
      3:       tgt = 2047;
      4:       tgt = 1;
      default: tgt = $urandom_range(2, 40);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: max_att = $urandom_range(1, 6);
      4:          max_att = 24'hFFFFFF;
      5:          max_att = 0;
      6:          max_att = 1;
      default:    max_att = $urandom_range(7, 24'hFFFFFF);
    endcase
    apply_settings(bw, bh, r, tgt, max_att);
    phase_len = (budget < 60) ? budget : 60;
    n_items = 0;
    while (n_items < phase_len) begin
      push_cand(1'b1, int'($urandom_range(65535)), int'($urandom_range(65535)));
      run_len = $urandom_range(3, 30);
      if (run_len > phase_len - n_items - 1) run_len = phase_len - n_items - 1;
      for (k = 0; k < run_len; k++)
        push_cand($urandom_range(14) == 0, pick_coord(bw), pick_coord(bh));
      n_items += run_len + 1;
    end
  endtask

  // Stimulus sequence
  initial begin
    int phases;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: first disk, direct overlap, coordinate extremes,
    // restart that reuses the store, overlap across the periodic boundary
    push_cand(1'b0, 0, 0);
    push_cand(1'b0, 0, 0);
    push_cand(1'b0, -32768, -32768);
    push_cand(1'b0, 32767, 32767);
    push_cand(1'b1, 32767, -32768);
    push_cand(1'b0, 255, 255);
    push_cand(1'b0, 1, 0);
    wait_idle();

    // Zero width, full height, largest radius, zero attempts: first hit gives up
    apply_settings(0, 16'hFFFF, 32767, 2, 0);
    push_cand(1'b1, 0, 0);
    push_cand(1'b0, 100, -100);
    push_cand(1'b0, -30000, 30000);
    push_cand(1'b0, 7, 7);
    wait_idle();

    // Target of zero: nothing can be placed
    apply_settings(16'hFFFF, 1, 0, 0, 1);
    push_cand(1'b1, 0, 0);
    push_cand(1'b0, 3, 3);
    wait_idle();

    // Zero radius never overlaps; then the target is lowered under the count
    apply_settings(16'hFFFF, 1, 0, 5, 1);
    push_cand(1'b1, 0, 0);
    push_cand(1'b0, 0, 0);
    push_cand(1'b0, 0, 0);
    wait_idle();
    write_reg(CFG_TARGET_COUNT, 1);
    end_writes();
    push_cand(1'b0, 5, 5);
    wait_idle();

    // Unit box, coordinates far outside it, run ending on the target
    apply_settings(1, 1, 200, 3, 24'hFFFFFF);
    push_cand(1'b1, 0, 0);
    push_cand(1'b0, 0, 0);
    push_cand(1'b0, 1000, 0);
    push_cand(1'b0, 0, 300);
    push_cand(1'b0, -5000, -5000);
    push_cand(1'b0, 1, 1);
    wait_idle();

    // Random runs until the request budget is used up or the phase cap is reached
    phases = 0;
    while (req_count < ITEM_TARGET && phases < 40) begin
      random_phase(ITEM_TARGET - req_count);
      wait_idle();
      phases++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_periodic_disk_placement_check_top: clean");
    else
      $display("tb_periodic_disk_placement_check_top: errors");
    $finish;
  end

endmodule
